[rtl/srms_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter: shared types and constants
// Word layouts of both channels, accumulator widths, saturation limits and the
// Q0.16 smoothing coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package srms_pkg;

	// Accumulator and divider widths.
	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 31;   // square of a Q1.15 sample, at most 2^30
	localparam int SUM_W    = 48;
	localparam int CNT_W    = 12;
	localparam int ROOT_W   = SUM_W / 2;
	localparam int LEVEL_W  = 32;
	localparam int OUT_W    = 16;

	// Saturation limits of the running sum and the sample count.
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Q0.16 smoothing coefficients; they add up to one.
	localparam logic [15:0] COEF_OLD = 16'd65208;
	localparam logic [8:0]  COEF_NEW = 9'd328;
	localparam logic [47:0] ROUND_HALF = 48'd32768;

	// Input word: one interleaved stereo frame.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       last_frame;
	} frame_t;

	// Output word: block RMS and smoothed level.
	typedef struct packed {
		logic [OUT_W-1:0] block_rms;
		logic [OUT_W-1:0] smoothed_level;
	} level_t;

	// Request from the merging stage to the divider at the end of a buffer.
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} div_req_t;

endpackage

`default_nettype wire

[rtl/srms_stream_if.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter: valid/ready stream channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface srms_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/srms_lane.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter: squaring lane
// Squares one channel's sample of an accepted frame into a stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_lane (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [srms_pkg::SAMPLE_W-1:0] sample,
	output logic [srms_pkg::SQ_W-1:0]                 sq_s1
);

	logic signed [2*srms_pkg::SAMPLE_W-1:0] prod;

	// The square is never negative and fits below the sign bit.
	assign prod = sample * sample;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= prod[srms_pkg::SQ_W-1:0];
		end
	end

endmodule

`default_nettype wire

[rtl/srms_merge.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter: merging stage
// Adds both lane squares to the saturating running sum, counts samples, and
// hands the finished sum and count to the divider on the last frame.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_merge (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          acc,
	input  wire logic                          last,
	input  wire logic [srms_pkg::SQ_W-1:0]     sq_left,
	input  wire logic [srms_pkg::SQ_W-1:0]     sq_right,
	output srms_pkg::div_req_t                 req
);

	logic                          valid_s1;
	logic                          last_s1;
	logic [srms_pkg::SUM_W-1:0]    sum_q;
	logic [srms_pkg::CNT_W-1:0]    cnt_q;
	logic                          start_q;
	logic [srms_pkg::SUM_W-1:0]    req_sum_q;
	logic [srms_pkg::CNT_W-1:0]    req_cnt_q;
	logic [srms_pkg::SUM_W:0]      sum_ext;
	logic [srms_pkg::CNT_W:0]      cnt_ext;
	logic [srms_pkg::SUM_W-1:0]    sum_next;
	logic [srms_pkg::CNT_W-1:0]    cnt_next;

	// Saturating updates of the sum and the count.
	always_comb begin
		sum_ext = {1'b0, sum_q} + (srms_pkg::SUM_W+1)'(sq_left)
			+ (srms_pkg::SUM_W+1)'(sq_right);
		cnt_ext = {1'b0, cnt_q} + (srms_pkg::CNT_W+1)'(2);
		sum_next = (sum_ext > {1'b0, srms_pkg::SUM_MAX}) ? srms_pkg::SUM_MAX
			: sum_ext[srms_pkg::SUM_W-1:0];
		cnt_next = (cnt_ext > {1'b0, srms_pkg::CNT_MAX}) ? srms_pkg::CNT_MAX
			: cnt_ext[srms_pkg::CNT_W-1:0];
	end

	// Stage flags, running state and the divider launch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
			start_q  <= 1'b0;
		end else begin
			valid_s1 <= acc;
			last_s1  <= acc & last;
			start_q  <= valid_s1 & last_s1;
			if (valid_s1) begin
				if (last_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

	// Finished totals for the divider.
	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			req_sum_q <= sum_next;
			req_cnt_q <= cnt_next;
		end
	end

	assign req.start = start_q;
	assign req.sum   = req_sum_q;
	assign req.count = req_cnt_q;

endmodule

`default_nettype wire

[rtl/srms_div.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter: mean divider
// Restoring division of the sum by the sample count, one quotient bit per
// cycle. A zero count gives a zero mean.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  srms_pkg::div_req_t                 req,
	output logic                               done,
	output logic [srms_pkg::SUM_W-1:0]         quotient
);

	localparam int STEP_W = $clog2(srms_pkg::SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(srms_pkg::SUM_W - 1);

	logic                          run_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic                          zero_q;
	logic [srms_pkg::CNT_W-1:0]    divisor_q;
	logic [srms_pkg::CNT_W-1:0]    rem_q;
	logic [srms_pkg::SUM_W-1:0]    quo_q;
	logic [srms_pkg::CNT_W:0]      rem_sh;
	logic [srms_pkg::CNT_W:0]      rem_sub;
	logic                          take;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh  = {rem_q, quo_q[srms_pkg::SUM_W-1]};
		rem_sub = rem_sh - {1'b0, divisor_q};
		take    = rem_sh >= {1'b0, divisor_q};
	end

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.count;
			zero_q    <= (req.count == '0);
			rem_q     <= '0;
			quo_q     <= req.sum;
		end else if (run_q) begin
			rem_q <= take ? rem_sub[srms_pkg::CNT_W-1:0] : rem_sh[srms_pkg::CNT_W-1:0];
			quo_q <= {quo_q[srms_pkg::SUM_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

[rtl/srms_sqrt.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter: integer square root
// Digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srms_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [srms_pkg::SUM_W-1:0]    radicand,
	output logic                               done,
	output logic [srms_pkg::ROOT_W-1:0]        root
);

	localparam int STEP_W = $clog2(srms_pkg::ROOT_W);
	localparam int REM_W  = srms_pkg::ROOT_W + 2;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(srms_pkg::ROOT_W - 1);

	logic                          run_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [srms_pkg::SUM_W-1:0]    val_q;
	logic [REM_W-1:0]              rem_q;
	logic [srms_pkg::ROOT_W-1:0]   root_q;
	logic [REM_W+1:0]              rem_sh;
	logic [REM_W+1:0]              trial;
	logic [REM_W+1:0]              rem_sub;
	logic                          take;

	// Bring down the next bit pair and compare against 4*root + 1.
	always_comb begin
		rem_sh  = {rem_q, val_q[srms_pkg::SUM_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		take    = rem_sh >= trial;
	end

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= {val_q[srms_pkg::SUM_W-3:0], 2'b00};
			rem_q  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[srms_pkg::ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

[rtl/stereo_rms_level_meter_core.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter core
// Two squaring lanes feed a merging accumulator; at the end of each buffer the
// mean is divided out, square-rooted and folded into a one-pole smoothed level.
//
// Usage:
//   frame (sink) takes one stereo frame per word: left_sample, right_sample
//   (signed Q1.15) and last_frame. Frames without last_frame are accepted one
//   per cycle and only accumulate. A frame with last_frame closes the buffer.
//   level (source) gives one word per buffer: block_rms and smoothed_level,
//   both unsigned Q1.15.
//   After the last frame is accepted, its result passes through the squaring
//   lanes, the merging stage, the mean divider, the square root and the root register.
//   frame.ready stays low from the last frame until its result is loaded into
//   the output register, so the next buffer cannot start before that.
//   If the receiver stalls, the result waits in the output register while the
//   next buffer accumulates; a later result waits in the root register until
//   the output register is free.
//   Reset clears the running sum, the sample count and the smoothed level;
//   frame.ready is high right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_rms_level_meter_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	srms_stream_if.sink        frame,
	srms_stream_if.source      level
);

	logic                               acc;
	logic [srms_pkg::SQ_W-1:0]          sq_s1 [2];
	srms_pkg::div_req_t                 div_req;
	logic                               div_done;
	logic [srms_pkg::SUM_W-1:0]         mean;
	logic                               sqrt_done;
	logic [srms_pkg::ROOT_W-1:0]        root;
	logic                               busy_q;
	logic                               rms_valid_q;
	logic [srms_pkg::OUT_W-1:0]         rms_q;
	logic [srms_pkg::LEVEL_W-1:0]       level_q;
	logic                               out_valid_q;
	srms_pkg::level_t                   out_q;
	logic                               load_out;
	logic [47:0]                        prod_old;
	logic [24:0]                        prod_new;
	logic [srms_pkg::LEVEL_W-1:0]       rounded;
	logic [srms_pkg::LEVEL_W:0]         acc_sum;
	logic [srms_pkg::LEVEL_W-1:0]       acc_sat;

	// Input handshake: hold off while a buffer's result is being computed.
	assign frame.ready = !busy_q;
	assign acc         = frame.valid && frame.ready;

	// One squaring lane per channel.
	srms_lane u_lane_left (
		.clk    (clk),
		.en     (acc),
		.sample (frame.data.left_sample),
		.sq_s1  (sq_s1[0])
	);

	srms_lane u_lane_right (
		.clk    (clk),
		.en     (acc),
		.sample (frame.data.right_sample),
		.sq_s1  (sq_s1[1])
	);

	// Merge the lanes into the running sum and count.
	srms_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.last     (frame.data.last_frame),
		.sq_left  (sq_s1[0]),
		.sq_right (sq_s1[1]),
		.req      (div_req)
	);

	// Mean of the squares, then its square root.
	srms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (mean)
	);

	srms_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_done),
		.radicand (mean),
		.done     (sqrt_done),
		.root     (root)
	);

	// Smoothing: round(level * 0.995) + rms * 0.005, saturated in Q1.31.
	always_comb begin
		prod_old = level_q * srms_pkg::COEF_OLD;
		prod_new = rms_q * srms_pkg::COEF_NEW;
		rounded  = srms_pkg::LEVEL_W'((prod_old + srms_pkg::ROUND_HALF) >> 16);
		acc_sum  = {1'b0, rounded} + (srms_pkg::LEVEL_W+1)'(prod_new);
		acc_sat  = acc_sum[srms_pkg::LEVEL_W] ? {srms_pkg::LEVEL_W{1'b1}}
			: acc_sum[srms_pkg::LEVEL_W-1:0];
	end

	assign load_out = rms_valid_q && (!out_valid_q || level.ready);

	// Control and smoothed state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rms_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
		end else begin
			if (acc && frame.data.last_frame) begin
				busy_q <= 1'b1;
			end
			if (sqrt_done) begin
				rms_valid_q <= 1'b1;
			end
			if (load_out) begin
				level_q     <= acc_sat;
				rms_valid_q <= 1'b0;
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (level.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Clamped root and the output word.
	always_ff @(posedge clk) begin
		if (sqrt_done) begin
			rms_q <= (root[srms_pkg::ROOT_W-1:srms_pkg::OUT_W] != '0)
				? {srms_pkg::OUT_W{1'b1}} : root[srms_pkg::OUT_W-1:0];
		end
		if (load_out) begin
			out_q.block_rms      <= rms_q;
			out_q.smoothed_level <= acc_sat[srms_pkg::LEVEL_W-1 -: srms_pkg::OUT_W];
		end
	end

	assign level.valid = out_valid_q;
	assign level.data  = out_q;

`ifndef SYNTHESIS
	// A closing frame always opens a busy window.
	a_last_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && frame.data.last_frame |=> busy_q)
		else $error("last frame accepted without entering busy");

	// The divider is launched only for a closed buffer.
	a_div_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> busy_q)
		else $error("divider launched outside a busy window");

	// A new root never overwrites one still waiting for the output register.
	a_no_root_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> !rms_valid_q)
		else $error("root result overwritten");

	// A pending root implies the input side is still held off.
	a_root_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rms_valid_q |-> busy_q)
		else $error("pending root while input accepted");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Stereo RMS level meter core: self-checking testbench
// Stereo frames go in on the frame channel and every result word from the
// level channel is checked against a level predictor that runs in step with
// the accepted frames. A directed pass covers sample extremes and short
// buffers. A long-buffer pass sends one buffer of
// 300 frames. A random pass sends buffers of mixed length and amplitude
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no word moving on either channel before the run is abandoned.
	localparam int unsigned STALL_LIMIT = 4000;
	// Quiet cycles after the last result, in which any extra result word would show.
	localparam int unsigned TAIL_CYCLES = 120;
	// Random frames sent per idle phase.
	localparam int unsigned FRAMES_PER_PHASE = 210;

	typedef enum {STYLE_FULL, STYLE_SCALED, STYLE_EXTREME} sample_style_t;

	logic clk = 1'b0;
	logic arst_n;

	srms_stream_if #(.payload_t(srms_pkg::frame_t)) frame_ch ();
	srms_stream_if #(.payload_t(srms_pkg::level_t)) level_ch ();

	stereo_rms_level_meter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.level  (level_ch)
	);

	always #6 clk = ~clk;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// Predictor state: running sum, sample count and smoothed level.
	logic [srms_pkg::SUM_W-1:0]   run_sum    = '0;
	logic [srms_pkg::CNT_W-1:0]   run_count  = '0;
	logic [srms_pkg::LEVEL_W-1:0] level_acc  = '0;

	// Result words predicted but not yet seen on the level channel.
	srms_pkg::level_t expected_levels[$];
	srms_pkg::level_t want_level;

	function automatic longint unsigned floor_root_clip(input longint unsigned root);
		return root;
	endfunction

	// Largest root whose square does not exceed the value, one bit at a time.
	function automatic longint unsigned floor_root(input longint unsigned value);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 23; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= value)
				root = trial;
		end
		return floor_root_clip(root);
	endfunction

	// Accumulates one frame; at the end of a buffer computes the result word.
	function automatic bit predict_level(input srms_pkg::frame_t f,
			output srms_pkg::level_t res);
		longint          l;
		longint          r;
		longint unsigned add;
		longint unsigned mean;
		longint unsigned rms;
		longint unsigned acc;
		l = f.left_sample;
		r = f.right_sample;
		add = longint'(l * l + r * r);
		res = '0;

		if (64'(run_sum) + add > 64'(srms_pkg::SUM_MAX))
			run_sum = srms_pkg::SUM_MAX;
		else
			run_sum = run_sum + add;
		if (run_count > srms_pkg::CNT_MAX - 12'd2)
			run_count = srms_pkg::CNT_MAX;
		else
			run_count = run_count + 12'd2;

		if (!f.last_frame)
			return 1'b0;

		// The last frame always adds samples, but a zero count gives a zero mean.
		mean = (run_count != 0) ? 64'(run_sum) / 64'(run_count) : 64'd0;
		rms = floor_root(mean);
		if (rms > 64'hFFFF)
			rms = 64'hFFFF;

		acc = ((64'(level_acc) * srms_pkg::COEF_OLD + srms_pkg::ROUND_HALF) >> 16)
			+ rms * srms_pkg::COEF_NEW;
		if (acc > 64'hFFFF_FFFF)
			acc = 64'hFFFF_FFFF;
		level_acc = acc[31:0];

		res.block_rms      = rms[15:0];
		res.smoothed_level = acc[31:16];
		run_sum   = '0;
		run_count = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Sends one frame word, idling first at random, and predicts its result.
	task automatic send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
			input logic last);
		srms_pkg::frame_t f;
		srms_pkg::level_t res;
		f.left_sample  = left;
		f.right_sample = right;
		f.last_frame   = last;
		while ($urandom_range(99) < send_idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data  <= f;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		if (predict_level(f, res))
			expected_levels = {expected_levels, res};
	endtask

	function automatic logic signed [15:0] random_sample(input sample_style_t style,
			input int unsigned amp_shift);
		logic signed [15:0] s;
		case (style)
			STYLE_FULL: begin
				s = 16'($urandom);
			end
			STYLE_SCALED: begin
				s = $signed(16'($urandom)) >>> amp_shift;
			end
			default: begin
				case ($urandom_range(3))
					0: s = 16'sh8000;
					1: s = 16'sh7FFF;
					2: s = 16'sh0000;
					default: s = -16'sd1;
				endcase
			end
		endcase
		return s;
	endfunction

	// Sends a whole buffer of random frames in one sample style.
	task automatic send_buffer(input int unsigned frames, input sample_style_t style);
		int unsigned amp_shift;
		amp_shift = $urandom_range(15);
		for (int unsigned i = 0; i < frames; i++)
			send_frame(random_sample(style, amp_shift), random_sample(style, amp_shift),
				i == frames - 1);
	endtask

	// Sample extremes, one-frame buffers and short mixed buffers.
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_frame(16'sd0, 16'sd0, 1'b1);
		send_frame(-16'sd32768, -16'sd32768, 1'b1);
		send_frame(16'sd32767, 16'sd32767, 1'b1);
		send_frame(16'sd32767, -16'sd32768, 1'b1);
		send_frame(16'sd1, -16'sd1, 1'b1);
		send_frame(-16'sd1, 16'sd0, 1'b0);
		send_frame(16'sd0, 16'sd1, 1'b1);
		send_frame(-16'sd32768, 16'sd32767, 1'b0);
		send_frame(16'sd16384, -16'sd16384, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0);
		send_frame(16'sd12345, -16'sd12345, 1'b1);
		for (int i = 0; i < 4; i++)
			send_frame(-16'sd32768, -16'sd32768, i == 3);
		send_frame(16'sd0, 16'sd0, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b1);
		send_frame(16'sh5555, 16'shAAAA, 1'b1);
	endtask

	// A buffer of 300 frames, then a short one after it.
	task automatic test_long_buffer();
		send_idle_pct  = 0;
		recv_stall_pct = 13;
		send_buffer(300, STYLE_FULL);
		// A short buffer right after shows the running state was cleared.
		send_buffer(3, STYLE_EXTREME);
	endtask

	// Buffers of random length and amplitude under each idle pattern.
	task automatic test_random();
		int unsigned idle_plan[4]  = '{0, 64, 0, 13};
		int unsigned stall_plan[4] = '{0, 0, 64, 13};
		int unsigned sent;
		int unsigned frames;
		int unsigned pick;
		sample_style_t style;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_plan[p];
			recv_stall_pct = stall_plan[p];
			sent = 0;
			while (sent < FRAMES_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 80)
					frames = $urandom_range(1, 12);
				else if (pick < 95)
					frames = $urandom_range(13, 64);
				else
					frames = $urandom_range(65, 300);
				pick = $urandom_range(99);
				if (pick < 45)
					style = STYLE_FULL;
				else if (pick < 85)
					style = STYLE_SCALED;
				else
					style = STYLE_EXTREME;
				send_buffer(frames, style);
				sent += frames;
			end
		end
	endtask

	// Receiver: ready is redrawn every cycle from the stall percentage.
	always @(posedge clk)
		level_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Checks each accepted result word against the oldest predicted one.
	always @(posedge clk) begin
		if (arst_n && level_ch.valid && level_ch.ready) begin
			if (expected_levels.size() == 0) begin
				report_mismatch("unexpected result word, block_rms", level_ch.data.block_rms, 0);
			end else begin
				want_level = expected_levels.pop_front();
				if (level_ch.data.block_rms !== want_level.block_rms)
					report_mismatch("block_rms", level_ch.data.block_rms,
						want_level.block_rms);
				if (level_ch.data.smoothed_level !== want_level.smoothed_level)
					report_mismatch("smoothed_level", level_ch.data.smoothed_level,
						want_level.smoothed_level);
			end
		end
	end

	// Watchdog: ends the run when no word has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_ch.valid && frame_ch.ready) || (level_ch.valid && level_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TIMEOUT: no word moved for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.data  = '0;
		level_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_long_buffer();
		test_random();
		frame_ch.valid <= 1'b0;

		// Drain the outstanding results, then give the core time to show extras.
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
